// ===== src/ltbt_pkg.sv =====
// ----------------------------------------------------------------------------
// ltbt_pkg
// Shared types and constants of the lagged trailing band tracker: field widths,
// configuration register indexes and their reset values, and the per-series
// band state word.
// ----------------------------------------------------------------------------
package ltbt_pkg;

  localparam int SERIES_W = 6;
  localparam int CLOSE_W  = 32;
  localparam int WINDOW_W = 6;
  localparam int BAND_W   = 16;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 40;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DAYS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_FRACTION = 1'b1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd15;
  localparam logic [BAND_W-1:0]   BAND_RESET   = 16'd2621;

  localparam int PROD_W = CLOSE_W + BAND_W + 1;

  typedef struct packed {
    logic               track;
    logic               sold;
    logic [CLOSE_W-1:0] ref_level;
  } band_state_t;

endpackage

// ===== src/ltbt_band_calc.sv =====
// ----------------------------------------------------------------------------
// ltbt_band_calc
// Scales the lagged close by one plus and one minus the band fraction, with
// one register stage after the multipliers, and works out the next band state
// of a series from its current state and the new close.
// ----------------------------------------------------------------------------
module ltbt_band_calc (
  input  logic                                clk,
  input  logic                                advance,
  input  logic [ltbt_pkg::CLOSE_W-1:0]        lagged_close,
  input  logic [ltbt_pkg::BAND_W-1:0]         band_fraction,
  input  logic [ltbt_pkg::CLOSE_W-1:0]        close_price,
  input  logic                                below_lagged,
  input  ltbt_pkg::band_state_t               state_cur,
  output ltbt_pkg::band_state_t               state_next
);

  localparam int PW = ltbt_pkg::PROD_W;
  localparam int CW = ltbt_pkg::CLOSE_W;
  localparam int BW = ltbt_pkg::BAND_W;

  logic [BW:0]   up_mult;
  logic [BW:0]   down_mult;
  logic [PW-1:0] prod_up;
  logic [PW-1:0] prod_down;
  logic [CW-1:0] up_level;
  logic [CW-1:0] down_level;

  assign up_mult   = {1'b1, {BW{1'b0}}} + {1'b0, band_fraction};
  assign down_mult = {1'b1, {BW{1'b0}}} - {1'b0, band_fraction};

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_up   <= {{(PW-CW){1'b0}}, lagged_close} * {{(PW-BW-1){1'b0}}, up_mult};
      prod_down <= {{(PW-CW){1'b0}}, lagged_close} * {{(PW-BW-1){1'b0}}, down_mult};
    end
  end

  assign up_level   = prod_up[PW-1] ? {CW{1'b1}} : prod_up[PW-2:BW];
  assign down_level = prod_down[PW-2:BW];

  always_comb begin
    state_next = state_cur;
    priority if (!state_cur.track) begin
      state_next.track     = 1'b1;
      state_next.sold      = below_lagged;
      state_next.ref_level = below_lagged ? up_level : down_level;
    end else if (state_cur.sold) begin
      if (close_price > state_cur.ref_level) begin
        state_next.sold      = 1'b0;
        state_next.ref_level = down_level;
      end else if (up_level < state_cur.ref_level) begin
        state_next.ref_level = up_level;
      end
    end else begin
      if (close_price < state_cur.ref_level) begin
        state_next.sold      = 1'b1;
        state_next.ref_level = up_level;
      end else if (down_level > state_cur.ref_level) begin
        state_next.ref_level = down_level;
      end
    end
  end

endmodule

// ===== src/lagged_trailing_band_tracker.sv =====
// ----------------------------------------------------------------------------
// lagged_trailing_band_tracker
// Per-series trailing band tracker. Each close is stored in a ring memory of
// its series; the close from a configurable number of items earlier sets a
// band that ratchets toward the price and flips side when the price crosses.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   series_index, close_price
//   m_axis    out        m_axis_tvalid/m_axis_tready   series_id, reference_level,
//                                                      sold_state; tuser: valid
//   cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item is accepted per cycle; the whole pipeline holds while a result
// waits on m_axis_tready. Each result passes stage registers a, b and c and
// the output register, set by the dependent reads of the pointer, history and
// band memories and the multiplier register. Reset clears the valid bits of
// the per-series pointer and band memories at once, so no clearing pass is run.
// ----------------------------------------------------------------------------
module lagged_trailing_band_tracker #(
  parameter int MAX_DAYS     = 32,
  parameter int SERIES_COUNT = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [5:0] series_index, [37:6] close_price, [39:38] zero
  input  logic [ltbt_pkg::TDATA_IN_W-1:0]        s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [5:0] series_id, [37:6] reference_level, [38] sold_state, [39] zero
  output logic [ltbt_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
  // [0] reference_valid
  output logic                                   m_axis_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ltbt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ltbt_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SW  = ltbt_pkg::SERIES_W;
  localparam int CW  = ltbt_pkg::CLOSE_W;
  localparam int SERIES_USED = (SERIES_COUNT < (2 ** SW)) ? SERIES_COUNT : (2 ** SW);
  localparam int SI_W   = (SERIES_USED > 1) ? $clog2(SERIES_USED) : 1;
  localparam int POS_W  = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int FILL_W = $clog2(MAX_DAYS + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int PTR_W  = FILL_W + POS_W;
  localparam int HIST_DEPTH = SERIES_USED * MAX_DAYS;
  localparam int HA_W   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  logic [ltbt_pkg::WINDOW_W-1:0] window_days;
  logic [ltbt_pkg::BAND_W-1:0]   band_fraction;

  logic adv;
  logic accept;
  logic [SW-1:0] in_series;
  logic [CW-1:0] in_close;

  logic          a_valid;
  logic [SW-1:0] a_series;
  logic [CW-1:0] a_close;
  logic          a_in_range;
  logic [SI_W-1:0] a_idx;

  logic [PTR_W-1:0]       ptr_mem [SERIES_USED];
  logic [SERIES_USED-1:0] ptr_vld;
  logic [PTR_W-1:0]       ptr_rd;
  logic                   ptr_rd_vld;
  logic                   ptr_we;
  logic [PTR_W-1:0]       ptr_wdata;
  logic                   ptr_byp_valid;
  logic [SI_W-1:0]        ptr_byp_idx;
  logic [PTR_W-1:0]       ptr_byp_data;
  logic [PTR_W-1:0]       ptr_cur;
  logic [FILL_W-1:0]      cur_fill;
  logic [POS_W-1:0]       cur_pos;
  logic [FILL_W-1:0]      fill_next;
  logic [POS_W-1:0]       pos_next;
  logic [FILL_W-1:0]      w_eff;
  logic                   a_hit;
  logic [SUM_W-1:0]       lag_sum;
  logic [POS_W-1:0]       lag_slot;

  logic [CW-1:0]   hist_mem [HIST_DEPTH];
  logic [CW-1:0]   hist_rd;
  logic [HA_W-1:0] hist_wr_addr;
  logic [HA_W-1:0] hist_rd_addr;

  logic          b_valid;
  logic [SW-1:0] b_series;
  logic [CW-1:0] b_close;
  logic          b_hit;
  logic [SI_W-1:0] b_idx;

  ltbt_pkg::band_state_t  band_mem [SERIES_USED];
  logic [SERIES_USED-1:0] band_vld;
  ltbt_pkg::band_state_t  band_rd;
  logic                   band_rd_vld;
  logic                   band_we;
  logic                   band_byp_valid;
  logic [SI_W-1:0]        band_byp_idx;
  ltbt_pkg::band_state_t  band_byp_data;
  ltbt_pkg::band_state_t  band_cur;
  ltbt_pkg::band_state_t  band_next;

  logic          c_valid;
  logic [SW-1:0] c_series;
  logic [CW-1:0] c_close;
  logic          c_hit;
  logic          c_below;
  logic [SI_W-1:0] c_idx;

  logic          out_valid;
  logic [SW-1:0] out_series;
  logic [CW-1:0] out_level;
  logic          out_ref_valid;
  logic          out_sold;

  // Configuration.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_days   <= ltbt_pkg::WINDOW_RESET;
      band_fraction <= ltbt_pkg::BAND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ltbt_pkg::CFG_WINDOW_DAYS:   window_days   <= cfg_data[ltbt_pkg::WINDOW_W-1:0];
        ltbt_pkg::CFG_BAND_FRACTION: band_fraction <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (window_days == '0) begin
      w_eff = FILL_W'(1);
    end else if (32'(window_days) > MAX_DAYS) begin
      w_eff = FILL_W'(MAX_DAYS);
    end else begin
      w_eff = FILL_W'(window_days);
    end
  end

  // Pipeline control.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign in_series     = s_axis_tdata[SW-1:0];
  assign in_close      = s_axis_tdata[SW+CW-1:SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= accept;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // Stage a: pointer memory read returns; ring slot and lag slot are worked out.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_series   <= in_series;
      a_close    <= in_close;
      a_in_range <= 32'(in_series) < SERIES_COUNT;
    end
  end

  assign a_idx = a_series[SI_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      ptr_rd <= ptr_mem[in_series[SI_W-1:0]];
      if (ptr_we) begin
        ptr_mem[a_idx] <= ptr_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_vld       <= '0;
      ptr_rd_vld    <= 1'b0;
      ptr_byp_valid <= 1'b0;
    end else if (adv) begin
      ptr_rd_vld    <= ptr_vld[in_series[SI_W-1:0]];
      ptr_byp_valid <= ptr_we;
      if (ptr_we) begin
        ptr_vld[a_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ptr_byp_idx  <= a_idx;
      ptr_byp_data <= ptr_wdata;
    end
  end

  always_comb begin
    if (ptr_byp_valid && ptr_byp_idx == a_idx) begin
      ptr_cur = ptr_byp_data;
    end else if (ptr_rd_vld) begin
      ptr_cur = ptr_rd;
    end else begin
      ptr_cur = '0;
    end
  end

  assign cur_fill  = ptr_cur[PTR_W-1:POS_W];
  assign cur_pos   = ptr_cur[POS_W-1:0];
  assign fill_next = (cur_fill < FILL_W'(MAX_DAYS)) ? cur_fill + FILL_W'(1) : cur_fill;
  assign pos_next  = (cur_pos == POS_W'(MAX_DAYS - 1)) ? '0 : cur_pos + POS_W'(1);
  assign ptr_wdata = {fill_next, pos_next};
  assign ptr_we    = adv && a_valid && a_in_range;
  assign a_hit     = a_in_range && (cur_fill >= w_eff);

  assign lag_sum  = SUM_W'(cur_pos) + SUM_W'(MAX_DAYS) - SUM_W'(w_eff);
  assign lag_slot = (lag_sum >= SUM_W'(MAX_DAYS)) ? POS_W'(lag_sum - SUM_W'(MAX_DAYS))
                                                   : POS_W'(lag_sum);

  assign hist_wr_addr = HA_W'(HA_W'(a_idx) * HA_W'(MAX_DAYS) + HA_W'(cur_pos));
  assign hist_rd_addr = HA_W'(HA_W'(a_idx) * HA_W'(MAX_DAYS) + HA_W'(lag_slot));

  always_ff @(posedge clk) begin
    if (adv) begin
      hist_rd <= hist_mem[hist_rd_addr];
      if (ptr_we) begin
        hist_mem[hist_wr_addr] <= a_close;
      end
    end
  end

  // Stage b: lagged close returns; band multipliers and band state read start.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_series <= a_series;
      b_close  <= a_close;
      b_hit    <= a_hit;
    end
  end

  assign b_idx = b_series[SI_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      band_rd <= band_mem[b_idx];
      if (band_we) begin
        band_mem[c_idx] <= band_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_vld       <= '0;
      band_rd_vld    <= 1'b0;
      band_byp_valid <= 1'b0;
    end else if (adv) begin
      band_rd_vld    <= band_vld[b_idx];
      band_byp_valid <= band_we;
      if (band_we) begin
        band_vld[c_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      band_byp_idx  <= c_idx;
      band_byp_data <= band_next;
    end
  end

  // Stage c: band decision and write back.
  always_ff @(posedge clk) begin
    if (adv) begin
      c_series <= b_series;
      c_close  <= b_close;
      c_hit    <= b_hit;
      c_below  <= b_close < hist_rd;
    end
  end

  assign c_idx = c_series[SI_W-1:0];

  always_comb begin
    if (band_byp_valid && band_byp_idx == c_idx) begin
      band_cur = band_byp_data;
    end else if (band_rd_vld) begin
      band_cur = band_rd;
    end else begin
      band_cur = '0;
    end
  end

  assign band_we = adv && c_valid && c_hit;

  ltbt_band_calc u_calc (
    .clk           (clk),
    .advance       (adv),
    .lagged_close  (hist_rd),
    .band_fraction (band_fraction),
    .close_price   (c_close),
    .below_lagged  (c_below),
    .state_cur     (band_cur),
    .state_next    (band_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_series    <= c_series;
      out_level     <= c_hit ? band_next.ref_level : '0;
      out_ref_valid <= c_hit;
      out_sold      <= c_hit && band_next.sold;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_sold, out_level, out_series};
  assign m_axis_tuser  = out_ref_valid;

  // Assertions.
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_in_range |-> cur_fill <= FILL_W'(MAX_DAYS))
    else $error("Fill count of a series exceeds the ring depth.");

  a_lag_slot_distinct: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_hit && w_eff != FILL_W'(MAX_DAYS) |-> lag_slot != cur_pos)
    else $error("Lagged read hits the slot being written.");

  a_band_written: assert property (@(posedge clk) disable iff (rst)
    adv && c_valid && c_hit |=> band_byp_valid && band_byp_data.track)
    else $error("Valid result left no tracking band state behind.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ref_valid |-> out_level == '0 && !out_sold)
    else $error("Invalid result carries a nonzero level or sold flag.");

endmodule

// ===== tb/sv/tb_lagged_trailing_band_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_lagged_trailing_band_tracker
// Self-checking testbench of the lagged trailing band tracker. A directed part
// covers the default window, window values below and above the legal range,
// band extremes with saturation, and window changes in the middle of a stream.
// Random phases then run price walks over small groups of series under varied
// settings. Each accepted close is run through a behavioral copy of the
// per-series band state. Every result is compared field by field with the
// oldest prediction. Random gaps are applied on both streams.
// ----------------------------------------------------------------------------
module tb_lagged_trailing_band_tracker;

  localparam int RING_DEPTH  = 32;
  localparam int SERIES_N    = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [ltbt_pkg::SERIES_W-1:0] id;
    logic [ltbt_pkg::CLOSE_W-1:0]  level;
    logic                          valid;
    logic                          sold;
  } band_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [ltbt_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [ltbt_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ltbt_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ltbt_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  lagged_trailing_band_tracker dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Behavioral copy of the per-series band state and the two settings.
  bit [ltbt_pkg::CLOSE_W-1:0]  close_ring [SERIES_N][RING_DEPTH];
  bit [5:0]                    closes_held [SERIES_N];
  bit [4:0]                    ring_slot [SERIES_N];
  bit                          sold_side [SERIES_N];
  bit [ltbt_pkg::CLOSE_W-1:0]  band_level [SERIES_N];
  bit                          band_started [SERIES_N];
  bit [ltbt_pkg::WINDOW_W-1:0] window_setting = ltbt_pkg::WINDOW_RESET;
  bit [ltbt_pkg::BAND_W-1:0]   band_setting = ltbt_pkg::BAND_RESET;

  band_result_t                pending_bands [$];
  int                          mismatches = 0;
  int                          cycle_count = 0;
  bit                          steady_flow = 1'b0;
  int                          stall_left = 0;
  bit [ltbt_pkg::CLOSE_W-1:0]  walk_close [SERIES_N];

  function automatic bit [ltbt_pkg::CLOSE_W-1:0] band_above(
      input bit [ltbt_pkg::CLOSE_W-1:0] q0);
    bit [63:0] p;
    p = ({32'b0, q0} * (64'd65536 + 64'(band_setting))) >> 16;
    return (p > 64'hFFFF_FFFF) ? '1 : p[31:0];
  endfunction

  function automatic bit [ltbt_pkg::CLOSE_W-1:0] band_below(
      input bit [ltbt_pkg::CLOSE_W-1:0] q0);
    bit [63:0] p;
    p = ({32'b0, q0} * (64'd65536 - 64'(band_setting))) >> 16;
    return p[31:0];
  endfunction

  function automatic void advance_band(input bit [ltbt_pkg::SERIES_W-1:0] s,
                                       input bit [ltbt_pkg::CLOSE_W-1:0] q,
                                       output band_result_t r);
    int                         w;
    int                         pos;
    bit [ltbt_pkg::CLOSE_W-1:0] q0;
    bit [ltbt_pkg::CLOSE_W-1:0] level;
    bit [ltbt_pkg::CLOSE_W-1:0] bound;
    bit                         sold;
    bit                         valid;
    w = int'(window_setting);
    if (w < 1) w = 1;
    if (w > RING_DEPTH) w = RING_DEPTH;
    pos = int'(ring_slot[s]);
    level = '0;
    sold = 1'b0;
    valid = 1'b0;
    if (int'(closes_held[s]) >= w) begin
      q0 = close_ring[s][(pos + RING_DEPTH - w) % RING_DEPTH];
      if (!band_started[s]) begin
        sold = q < q0;
        level = sold ? band_above(q0) : band_below(q0);
        band_started[s] = 1'b1;
      end else begin
        sold = sold_side[s];
        level = band_level[s];
        if (sold) begin
          if (q > level) begin
            sold = 1'b0;
            level = band_below(q0);
          end else begin
            bound = band_above(q0);
            if (bound < level) level = bound;
          end
        end else begin
          if (q < level) begin
            sold = 1'b1;
            level = band_above(q0);
          end else begin
            bound = band_below(q0);
            if (bound > level) level = bound;
          end
        end
      end
      sold_side[s] = sold;
      band_level[s] = level;
      valid = 1'b1;
    end
    close_ring[s][pos] = q;
    ring_slot[s] = 5'((pos + 1) % RING_DEPTH);
    if (int'(closes_held[s]) < RING_DEPTH) closes_held[s]++;
    r.id = s;
    r.level = valid ? level : '0;
    r.valid = valid;
    r.sold = valid && sold;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h, predicted %0h at cycle %0d",
             what, got, want, cycle_count);
  endtask

  always @(posedge clk) begin : band_monitor
    band_result_t fresh;
    band_result_t got;
    band_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ltbt_pkg::CFG_WINDOW_DAYS)
          window_setting = cfg_data[ltbt_pkg::WINDOW_W-1:0];
        else if (cfg_index == ltbt_pkg::CFG_BAND_FRACTION)
          band_setting = cfg_data[ltbt_pkg::BAND_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_band(s_axis_tdata[5:0], s_axis_tdata[37:6], fresh);
        pending_bands.push_back(fresh);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.id = m_axis_tdata[5:0];
        got.level = m_axis_tdata[37:6];
        got.sold = m_axis_tdata[38];
        got.valid = m_axis_tuser;
        if (pending_bands.size() == 0) begin
          report_mismatch("result with none pending", 64'(got), 64'(0));
        end else begin
          want = pending_bands.pop_front();
          if (got.id !== want.id)
            report_mismatch("series_id", 64'(got.id), 64'(want.id));
          if (got.level !== want.level)
            report_mismatch("reference_level", 64'(got.level), 64'(want.level));
          if (got.valid !== want.valid)
            report_mismatch("reference_valid", 64'(got.valid), 64'(want.valid));
          if (got.sold !== want.sold)
            report_mismatch("sold_state", 64'(got.sold), 64'(want.sold));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_close(input bit [ltbt_pkg::SERIES_W-1:0] s,
                            input bit [ltbt_pkg::CLOSE_W-1:0] q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, q, s};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_bands();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bands.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_setting(input logic [ltbt_pkg::CFG_IDX_W-1:0] idx,
                               input logic [ltbt_pkg::CFG_DATA_W-1:0] value);
    drain_bands();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_window();
    send_close(6'd0, 32'd1000);
    send_close(6'd63, 32'hFFFF_FFFF);
    send_close(6'd63, 32'd0);
  endtask

  task automatic test_window_limits();
    // Window zero behaves as one; the upper data bits must be ignored.
    write_setting(ltbt_pkg::CFG_WINDOW_DAYS, 16'hFFC0);
    send_close(6'd0, 32'hFFFF_FFFF);
    send_close(6'd0, 32'd0);
    send_close(6'd0, 32'hFFFF_FFFF);
    send_close(6'd0, 32'h8000_0000);
    write_setting(ltbt_pkg::CFG_BAND_FRACTION, 16'hFFFF);
    send_close(6'd0, 32'd0);
    send_close(6'd0, 32'hFFFF_FFFF);
    send_close(6'd0, 32'd1);
  endtask

  task automatic test_window_resize();
    write_setting(ltbt_pkg::CFG_BAND_FRACTION, 16'h8000);
    write_setting(ltbt_pkg::CFG_WINDOW_DAYS, 16'd2);
    send_close(6'd42, 32'd1000);
    send_close(6'd42, 32'd2000);
    send_close(6'd42, 32'd500);
    send_close(6'd42, 32'd3000);
    // A window above the ring depth acts as the full ring, so the series is
    // short of closes again and the result stays invalid.
    write_setting(ltbt_pkg::CFG_WINDOW_DAYS, 16'd63);
    send_close(6'd42, 32'd10);
    write_setting(ltbt_pkg::CFG_WINDOW_DAYS, 16'd1);
    send_close(6'd42, 32'd700);
    send_close(6'd42, 32'd5);
    send_close(6'd42, 32'd9000);
  endtask

  function automatic bit [ltbt_pkg::CLOSE_W-1:0] next_close(
      input bit [ltbt_pkg::SERIES_W-1:0] s);
    int        r;
    bit [63:0] v;
    bit [63:0] step;
    r = $urandom_range(0, 99);
    if (walk_close[s] == 0) walk_close[s] = $urandom_range(1000, 100000000);
    if (r < 5) begin
      walk_close[s] = $urandom;
    end else if (r < 8) begin
      walk_close[s] = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      v = 64'(walk_close[s]);
      step = v >> $urandom_range(3, 10);
      if ($urandom_range(0, 1)) v = v + step;
      else v = v - step;
      walk_close[s] = (v > 64'hFFFF_FFFF) ? '1 : v[31:0];
    end
    return walk_close[s];
  endfunction

  task automatic test_random_phases(input int phases, input int per_phase);
    bit [ltbt_pkg::SERIES_W-1:0] group [6];
    bit [ltbt_pkg::SERIES_W-1:0] s;
    bit [5:0]                    w;
    bit [15:0]                   band;
    int                          group_size;
    int                          r;
    for (int p = 0; p < phases; p++) begin
      r = $urandom_range(0, 9);
      unique case (r)
        0: w = 6'd0;
        1: w = 6'd63;
        2: w = 6'd32;
        3: w = 6'($urandom_range(33, 62));
        default: w = 6'($urandom_range(1, 8));
      endcase
      write_setting(ltbt_pkg::CFG_WINDOW_DAYS, {10'($urandom_range(0, 1023)), w});
      r = $urandom_range(0, 9);
      if (r == 0) band = 16'd0;
      else if (r == 1) band = 16'hFFFF;
      else if (r < 6) band = 16'($urandom_range(0, 4000));
      else band = 16'($urandom_range(0, 65535));
      write_setting(ltbt_pkg::CFG_BAND_FRACTION, band);
      group_size = $urandom_range(1, 6);
      for (int g = 0; g < group_size; g++) group[g] = 6'($urandom_range(0, 63));
      steady_flow = (p == 3);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 99) < 5) s = 6'($urandom_range(0, 63));
        else s = group[$urandom_range(0, group_size - 1)];
        send_close(s, next_close(s));
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_window_limits();
    test_window_resize();
    test_random_phases(12, 150);
    drain_bands();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ltbt_pkg.sv
src/ltbt_band_calc.sv
src/lagged_trailing_band_tracker.sv
tb/sv/tb_lagged_trailing_band_tracker.sv
